[sv/vao_pkg.sv]
// Shared types, constants and direction table for the voxel ambient occlusion shader.
`timescale 1ns / 1ps

package vao_pkg;

	localparam int MAX_DIM_DEF = 64;

	localparam int COORD_W    = 6;
	localparam int SIZE_W     = 7;
	localparam int LIMIT_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int SHADE_W    = 8;
	localparam int OPEN_W     = 5;
	localparam int DIR_W      = 5;
	localparam int STEP_W     = 9;
	localparam int FRAC_W     = 16;
	localparam int POS_W      = 25;
	localparam int SUM_W      = 10;

	typedef logic signed [POS_W-1:0] pos_t;

	localparam pos_t Q_ONE       = 25'sd65536;
	localparam pos_t Q_INV_SQRT2 = 25'sd46341;
	localparam pos_t Q_INV_SQRT3 = 25'sd37837;

	localparam logic [SUM_W-1:0]   BASE_SHADE  = 10'd50;
	localparam logic [SUM_W-1:0]   SHADE_MAX   = 10'd255;
	localparam logic [OPEN_W-1:0]  INCR_SMALL  = 5'd20;
	localparam logic [OPEN_W-1:0]  INCR_LARGE  = 5'd15;
	localparam logic [DIR_W-1:0]   RAYS_SMALL  = 5'd14;
	localparam logic [DIR_W-1:0]   RAYS_LARGE  = 5'd20;
	localparam logic [SIZE_W-1:0]  RESET_SIZE  = 7'd64;
	localparam logic [LIMIT_W-1:0] RESET_LIMIT = 8'd75;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SIZE_X    = 3'd0,
		CFG_SIZE_Y    = 3'd1,
		CFG_SIZE_Z    = 3'd2,
		CFG_RAY_LIMIT = 3'd3,
		CFG_DIR_SET   = 3'd4
	} cfg_idx_t;

	typedef logic [1:0] sign_t;
	localparam sign_t SG_ZERO = 2'b00;
	localparam sign_t SG_POS  = 2'b01;
	localparam sign_t SG_NEG  = 2'b11;

	// Ray start request from the sequencer to the marcher
	typedef struct packed {
		logic                   start;
		logic [DIR_W-1:0]       dir;
		logic [COORD_W-1:0]     x;
		logic [COORD_W-1:0]     y;
		logic [COORD_W-1:0]     z;
	} ray_cmd_t;

	// Ray outcome, valid for one cycle
	typedef struct packed {
		logic done;
		logic open;
	} ray_res_t;

	// Volume geometry and sample budget
	typedef struct packed {
		logic [2:0][SIZE_W-1:0] ext;
		logic [LIMIT_W-1:0]     limit;
	} ray_cfg_t;

	// Signs of one direction as {x, y, z}
	function automatic logic [5:0] dir_signs(input logic [DIR_W-1:0] idx);
		logic [5:0] s;
		begin
			case (idx)
				5'd0:    s = {SG_POS,  SG_POS,  SG_NEG};
				5'd1:    s = {SG_NEG,  SG_POS,  SG_NEG};
				5'd2:    s = {SG_POS,  SG_NEG,  SG_NEG};
				5'd3:    s = {SG_NEG,  SG_NEG,  SG_NEG};
				5'd4:    s = {SG_POS,  SG_POS,  SG_POS};
				5'd5:    s = {SG_NEG,  SG_POS,  SG_POS};
				5'd6:    s = {SG_POS,  SG_NEG,  SG_POS};
				5'd7:    s = {SG_NEG,  SG_NEG,  SG_POS};
				5'd8:    s = {SG_ZERO, SG_ZERO, SG_POS};
				5'd9:    s = {SG_ZERO, SG_POS,  SG_ZERO};
				5'd10:   s = {SG_POS,  SG_ZERO, SG_ZERO};
				5'd11:   s = {SG_ZERO, SG_ZERO, SG_NEG};
				5'd12:   s = {SG_ZERO, SG_NEG,  SG_ZERO};
				5'd13:   s = {SG_NEG,  SG_ZERO, SG_ZERO};
				5'd14:   s = {SG_ZERO, SG_NEG,  SG_NEG};
				5'd15:   s = {SG_NEG,  SG_NEG,  SG_ZERO};
				5'd16:   s = {SG_NEG,  SG_ZERO, SG_NEG};
				5'd17:   s = {SG_ZERO, SG_POS,  SG_POS};
				5'd18:   s = {SG_POS,  SG_POS,  SG_ZERO};
				5'd19:   s = {SG_POS,  SG_ZERO, SG_POS};
				default: s = {SG_POS,  SG_ZERO, SG_ZERO};
			endcase
			return s;
		end
	endfunction

	function automatic pos_t dir_comp(input sign_t s, input pos_t mag);
		pos_t v;
		begin
			case (s)
				SG_POS:  v = mag;
				SG_NEG:  v = -mag;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

[sv/vao_if.sv]
// Request and result channel interfaces of the voxel ambient occlusion shader.
`timescale 1ns / 1ps

interface vao_in_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [vao_pkg::COORD_W-1:0] pos_x;
	logic [vao_pkg::COORD_W-1:0] pos_y;
	logic [vao_pkg::COORD_W-1:0] pos_z;
	logic                        occupied;

	modport source(output valid, mode, pos_x, pos_y, pos_z, occupied, input ready);
	modport sink(input valid, mode, pos_x, pos_y, pos_z, occupied, output ready);
endinterface

interface vao_out_if;
	logic                        valid;
	logic                        ready;
	logic [vao_pkg::SHADE_W-1:0] shade;
	logic [vao_pkg::OPEN_W-1:0]  open_rays;

	modport source(output valid, shade, open_rays, input ready);
	modport sink(input valid, shade, open_rays, output ready);
endinterface

[sv/vao_store.sv]
// Occupancy memory: one row of MAX_DIM voxels along x per (y, z) pair.
`timescale 1ns / 1ps

module vao_store #(
	parameter int MAX_DIM = vao_pkg::MAX_DIM_DEF,
	localparam int DEPTH = MAX_DIM * MAX_DIM,
	localparam int RA_W = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [RA_W-1:0]    waddr,
	input  logic [MAX_DIM-1:0] wdata,
	input  logic               re,
	input  logic [RA_W-1:0]    raddr,
	output logic [MAX_DIM-1:0] rdata
);

	logic [MAX_DIM-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/vao_ray.sv]
// Ray marcher: one sample per cycle, memory read overlapped with the next bounds check.
`timescale 1ns / 1ps

module vao_ray #(
	parameter int MAX_DIM = vao_pkg::MAX_DIM_DEF,
	localparam int CW = $clog2(MAX_DIM),
	localparam int RA_W = $clog2(MAX_DIM * MAX_DIM)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vao_pkg::ray_cmd_t   cmd,
	input  vao_pkg::ray_cfg_t   cfg,
	output logic                rd_en,
	output logic [RA_W-1:0]     rd_addr,
	input  logic [MAX_DIM-1:0]  rd_row,
	output vao_pkg::ray_res_t   res
);

	typedef enum logic {R_IDLE, R_MARCH} rstate_t;

	rstate_t                        state_q;
	vao_pkg::pos_t                  p_q [3];
	vao_pkg::pos_t                  d_q [3];
	logic [vao_pkg::STEP_W-1:0]     step_q;
	logic                           pend_s1;
	logic [CW-1:0]                  xb_s1;

	logic [5:0]                     sg;
	logic [1:0]                     nz;
	vao_pkg::pos_t                  mag;
	vao_pkg::pos_t                  d_new [3];
	vao_pkg::pos_t                  p_init [3];
	logic [2:0]                     oob;
	logic                           lim_hit;
	logic                           samp_open;
	logic                           hit;
	logic                           march;
	logic [CW-1:0]                  fx;
	logic [CW-1:0]                  fy;
	logic [CW-1:0]                  fz;

	// Direction vector and start point, p = origin + 2d
	always_comb begin
		sg = vao_pkg::dir_signs(cmd.dir);
		nz = 2'((sg[5:4] != vao_pkg::SG_ZERO)) + 2'((sg[3:2] != vao_pkg::SG_ZERO))
			+ 2'((sg[1:0] != vao_pkg::SG_ZERO));
		case (nz)
			2'd1:    mag = vao_pkg::Q_ONE;
			2'd2:    mag = vao_pkg::Q_INV_SQRT2;
			default: mag = vao_pkg::Q_INV_SQRT3;
		endcase
		d_new[0] = vao_pkg::dir_comp(sg[5:4], mag);
		d_new[1] = vao_pkg::dir_comp(sg[3:2], mag);
		d_new[2] = vao_pkg::dir_comp(sg[1:0], mag);
		p_init[0] = vao_pkg::pos_t'({cmd.x, 16'h0}) + d_new[0] + d_new[0];
		p_init[1] = vao_pkg::pos_t'({cmd.y, 16'h0}) + d_new[1] + d_new[1];
		p_init[2] = vao_pkg::pos_t'({cmd.z, 16'h0}) + d_new[2] + d_new[2];
	end

	// Check the current sample; the previous sample's row is in rd_row
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			oob[a] = (p_q[a] <= 0)
				|| (p_q[a] >= $signed({2'b00, cfg.ext[a], 16'h0}));
		end
		march     = (state_q == R_MARCH);
		lim_hit   = (cfg.limit != '0) && (step_q > {1'b0, cfg.limit});
		samp_open = lim_hit || (oob != 3'b000);
		hit       = pend_s1 && rd_row[xb_s1];
		fx        = p_q[0][vao_pkg::FRAC_W +: CW];
		fy        = p_q[1][vao_pkg::FRAC_W +: CW];
		fz        = p_q[2][vao_pkg::FRAC_W +: CW];
		rd_en     = march && !hit && !samp_open;
		rd_addr   = RA_W'(fz) * RA_W'(MAX_DIM) + RA_W'(fy);
		res.done  = march && (hit || samp_open);
		res.open  = !hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			pend_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				R_IDLE: begin
					if (cmd.start) begin
						for (int a = 0; a < 3; a++) begin
							p_q[a] <= p_init[a];
							d_q[a] <= d_new[a];
						end
						step_q  <= vao_pkg::STEP_W'(1);
						pend_s1 <= 1'b0;
						state_q <= R_MARCH;
					end
				end
				R_MARCH: begin
					if (hit || samp_open) begin
						pend_s1 <= 1'b0;
						state_q <= R_IDLE;
					end else begin
						for (int a = 0; a < 3; a++) begin
							p_q[a] <= p_q[a] + d_q[a];
						end
						// hold the count once past any budget
						if (!step_q[vao_pkg::STEP_W-1]) begin
							step_q <= step_q + vao_pkg::STEP_W'(1);
						end
						pend_s1 <= 1'b1;
						xb_s1   <= fx;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

endmodule

[sv/voxel_ambient_occlusion_shader.sv]
// Top level of the voxel ambient occlusion shader: registers, sequencer, store and marcher.
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// item      in   valid/ready    mode, pos_x, pos_y, pos_z, occupied
// result    out  valid/ready    shade, open_rays
// cfg       in   cfg_we         cfg_index, cfg_data (no read-back)
//
// A voxel write passes through accept, row read and row write-back; a write
// outside the extents ends after the row read. A query marches the rays of
// the direction set in turn, 14 or 20 of them, with a reset ray limit of 75;
// one occupancy row read per sample on the single read port of the store.
// After reset the store is swept to zero, one row per cycle over all
// MAX_DIM*MAX_DIM rows; item.ready stays low during the sweep.
// The result register takes a finished query while the next request is
// accepted; a query that finishes with a result still held waits for it.

module voxel_ambient_occlusion_shader #(
	parameter int MAX_DIM = vao_pkg::MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	vao_in_if.sink                        item,
	vao_out_if.source                     result,
	input  logic                          cfg_we,
	input  logic [vao_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vao_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int RA_W  = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_DIM);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_WB,
		ST_RAY_GO,
		ST_RAY_WAIT,
		ST_FINISH
	} state_t;

	state_t                         state_q;

	// Configuration registers
	logic [vao_pkg::SIZE_W-1:0]     size_q [3];
	logic [vao_pkg::LIMIT_W-1:0]    limit_q;
	logic                           dir_set_q;

	// Held request
	logic [vao_pkg::COORD_W-1:0]    x_q;
	logic [vao_pkg::COORD_W-1:0]    y_q;
	logic [vao_pkg::COORD_W-1:0]    z_q;
	logic                           occ_q;

	// Query progress and result register
	logic [vao_pkg::DIR_W-1:0]      dir_q;
	logic [vao_pkg::OPEN_W-1:0]     open_q;
	logic                           out_valid_q;
	logic [vao_pkg::SHADE_W-1:0]    shade_q;
	logic [vao_pkg::OPEN_W-1:0]     open_out_q;
	logic [RA_W-1:0]                clr_q;

	vao_pkg::ray_cfg_t              ray_cfg;
	vao_pkg::ray_cmd_t              ray_cmd;
	vao_pkg::ray_res_t              ray_res;
	logic                           ray_rd_en;
	logic [RA_W-1:0]                ray_rd_addr;

	logic                           mem_we;
	logic [RA_W-1:0]                mem_waddr;
	logic [MAX_DIM-1:0]             mem_wdata;
	logic                           mem_re;
	logic [RA_W-1:0]                mem_raddr;
	logic [MAX_DIM-1:0]             mem_rdata;

	logic [RA_W-1:0]                wr_row;
	logic [CW-1:0]                  wr_bit;
	logic                           wr_inb;
	logic [vao_pkg::DIR_W-1:0]      ray_cnt;
	logic [vao_pkg::OPEN_W-1:0]     incr;
	logic [vao_pkg::OPEN_W-1:0]     open_sum;
	logic [vao_pkg::SUM_W-1:0]      shade_full;
	logic [vao_pkg::SHADE_W-1:0]    shade_sat;
	logic                           out_free;
	logic                           out_load;

	// Configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q[0] <= vao_pkg::RESET_SIZE;
			size_q[1] <= vao_pkg::RESET_SIZE;
			size_q[2] <= vao_pkg::RESET_SIZE;
			limit_q   <= vao_pkg::RESET_LIMIT;
			dir_set_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vao_pkg::CFG_SIZE_X:    size_q[0] <= cfg_data[vao_pkg::SIZE_W-1:0];
				vao_pkg::CFG_SIZE_Y:    size_q[1] <= cfg_data[vao_pkg::SIZE_W-1:0];
				vao_pkg::CFG_SIZE_Z:    size_q[2] <= cfg_data[vao_pkg::SIZE_W-1:0];
				vao_pkg::CFG_RAY_LIMIT: limit_q   <= cfg_data;
				vao_pkg::CFG_DIR_SET:   dir_set_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Extent per axis is the size register clipped to the store's dimension
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			ray_cfg.ext[a] = ({2'b00, size_q[a]} > 9'(MAX_DIM))
				? vao_pkg::SIZE_W'(MAX_DIM) : size_q[a];
		end
		ray_cfg.limit = limit_q;
	end

	// Write path: row address and bit of the held request
	always_comb begin
		wr_row = RA_W'(z_q) * RA_W'(MAX_DIM) + RA_W'(y_q);
		wr_bit = CW'(x_q);
		wr_inb = ({1'b0, x_q} < ray_cfg.ext[0]) && ({1'b0, y_q} < ray_cfg.ext[1])
			&& ({1'b0, z_q} < ray_cfg.ext[2]);
		mem_wdata = '0;
		if (state_q == ST_WR_WB) begin
			mem_wdata = mem_rdata;
			mem_wdata[wr_bit] = occ_q;
		end
	end

	// Store port steering: sweep and write-back share the write port, the
	// write path and the marcher share the read port
	always_comb begin
		mem_we    = (state_q == ST_CLEAR) || (state_q == ST_WR_WB);
		mem_waddr = (state_q == ST_CLEAR) ? clr_q : wr_row;
		mem_re    = ((state_q == ST_WR_RD) && wr_inb) || ray_rd_en;
		mem_raddr = (state_q == ST_WR_RD) ? wr_row : ray_rd_addr;
	end

	always_comb begin
		ray_cmd.start = (state_q == ST_RAY_GO);
		ray_cmd.dir   = dir_q;
		ray_cmd.x     = x_q;
		ray_cmd.y     = y_q;
		ray_cmd.z     = z_q;
	end

	// Shade from the open count, saturated
	always_comb begin
		ray_cnt    = dir_set_q ? vao_pkg::RAYS_LARGE : vao_pkg::RAYS_SMALL;
		incr       = dir_set_q ? vao_pkg::INCR_LARGE : vao_pkg::INCR_SMALL;
		open_sum   = open_q + vao_pkg::OPEN_W'(ray_res.open);
		shade_full = vao_pkg::BASE_SHADE
			+ vao_pkg::SUM_W'(incr) * vao_pkg::SUM_W'(open_q);
		shade_sat  = (shade_full > vao_pkg::SHADE_MAX)
			? vao_pkg::SHADE_W'(vao_pkg::SHADE_MAX) : shade_full[vao_pkg::SHADE_W-1:0];
		out_free   = !out_valid_q || result.ready;
		out_load   = (state_q == ST_FINISH) && out_free;
	end

	assign item.ready       = (state_q == ST_IDLE);
	assign result.valid     = out_valid_q;
	assign result.shade     = shade_q;
	assign result.open_rays = open_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			dir_q       <= '0;
			open_q      <= '0;
		end else begin
			// load a finished query, else drop the result once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + RA_W'(1);
					if (clr_q == RA_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item.valid) begin
						x_q    <= item.pos_x;
						y_q    <= item.pos_y;
						z_q    <= item.pos_z;
						occ_q  <= item.occupied;
						dir_q  <= '0;
						open_q <= '0;
						state_q <= item.mode ? ST_RAY_GO : ST_WR_RD;
					end
				end
				ST_WR_RD: begin
					state_q <= wr_inb ? ST_WR_WB : ST_IDLE;
				end
				ST_WR_WB: begin
					state_q <= ST_IDLE;
				end
				ST_RAY_GO: begin
					state_q <= ST_RAY_WAIT;
				end
				ST_RAY_WAIT: begin
					if (ray_res.done) begin
						open_q <= open_sum;
						dir_q  <= dir_q + vao_pkg::DIR_W'(1);
						state_q <= (dir_q == ray_cnt - vao_pkg::DIR_W'(1))
							? ST_FINISH : ST_RAY_GO;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						shade_q     <= shade_sat;
						open_out_q  <= open_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	vao_store #(
		.MAX_DIM(MAX_DIM)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	vao_ray #(
		.MAX_DIM(MAX_DIM)
	) u_ray (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (ray_cmd),
		.cfg     (ray_cfg),
		.rd_en   (ray_rd_en),
		.rd_addr (ray_rd_addr),
		.rd_row  (mem_rdata),
		.res     (ray_res)
	);

`ifndef SYNTHESIS
	// No request is taken while the sweep is running
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !item.ready)
		else $error("request accepted during store sweep");

	// The write port and the marcher's read never collide
	a_port_split: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !ray_rd_en)
		else $error("store write overlaps a ray read");

	// A ray outcome only arrives while the sequencer waits for one
	a_ray_done: assert property (@(posedge clk) disable iff (!arst_n)
		ray_res.done |-> (state_q == ST_RAY_WAIT))
		else $error("ray outcome outside of wait state");

	// A new result only comes from a finished query
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised without a finished query");

	// Open count never exceeds the larger direction set
	a_open_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (open_out_q <= vao_pkg::RAYS_LARGE))
		else $error("open ray count out of range");
`endif

endmodule
